[rtl/field_square_mod_p25519_top_macros.svh]
// Assertion macros for the field square block.
`ifndef FIELD_SQUARE_MOD_P25519_TOP_MACROS_SVH
`define FIELD_SQUARE_MOD_P25519_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define FSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fsq_pkg.sv]
// Package: widths, stage map and types for the field square pipeline.
package fsq_pkg;

  localparam int LIMB_W  = 51;
  localparam int IN_W    = 52;
  localparam int N_LIMB  = 5;
  localparam int FOLD    = 19;
  localparam int OP_W    = 57;
  localparam int LO_W    = 29;
  localparam int HI_W    = OP_W - LO_W;
  localparam int PROD_W  = 2 * OP_W;
  localparam int COL_W   = 112;
  localparam int CARRY_W = COL_W - LIMB_W;
  localparam int FOLD_W  = 62;
  localparam int N_PROD  = 15;
  localparam int N_COL   = 5;
  localparam int TERMS   = N_PROD / N_COL;

  localparam int ST_PREP      = 0;
  localparam int ST_PP        = 1;
  localparam int ST_PROD      = 2;
  localparam int ST_COL       = 3;
  localparam int ST_CARRY     = 4;
  localparam int CARRY_STAGES = 6;
  localparam int N_STAGES     = ST_CARRY + CARRY_STAGES;

  typedef logic [IN_W-1:0]   in_limb_t;
  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [COL_W-1:0]  col_t;

endpackage

[rtl/fsq_if.sv]
// Channel interfaces: operand limbs in, square limbs out.
interface fsq_in_if;
  logic                   valid;
  logic                   ready;
  logic [fsq_pkg::IN_W-1:0] limb0_in;
  logic [fsq_pkg::IN_W-1:0] limb1_in;
  logic [fsq_pkg::IN_W-1:0] limb2_in;
  logic [fsq_pkg::IN_W-1:0] limb3_in;
  logic [fsq_pkg::IN_W-1:0] limb4_in;

  modport source (output valid, limb0_in, limb1_in, limb2_in, limb3_in, limb4_in,
                  input ready);
  modport sink   (input valid, limb0_in, limb1_in, limb2_in, limb3_in, limb4_in,
                  output ready);
endinterface

interface fsq_out_if;
  logic                       valid;
  logic                       ready;
  logic [fsq_pkg::LIMB_W-1:0] limb0_out;
  logic [fsq_pkg::IN_W-1:0]   limb1_out;
  logic [fsq_pkg::LIMB_W-1:0] limb2_out;
  logic [fsq_pkg::LIMB_W-1:0] limb3_out;
  logic [fsq_pkg::LIMB_W-1:0] limb4_out;

  modport source (output valid, limb0_out, limb1_out, limb2_out, limb3_out, limb4_out,
                  input ready);
  modport sink   (input valid, limb0_out, limb1_out, limb2_out, limb3_out, limb4_out,
                  output ready);
endinterface

[rtl/fsq_prep.sv]
// Operand stage: doubled and times-19 limbs, registered as fifteen factor pairs.
module fsq_prep (
  input  logic              clk,
  input  logic              en,
  input  fsq_pkg::in_limb_t a [fsq_pkg::N_LIMB],
  output fsq_pkg::op_t      x [fsq_pkg::N_PROD],
  output fsq_pkg::op_t      y [fsq_pkg::N_PROD]
);

  fsq_pkg::op_t ae [fsq_pkg::N_LIMB];
  fsq_pkg::op_t de [fsq_pkg::N_LIMB];
  fsq_pkg::op_t re [fsq_pkg::N_LIMB];

  always_comb begin
    for (int i = 0; i < fsq_pkg::N_LIMB; i++) begin
      ae[i] = fsq_pkg::OP_W'(a[i]);
      de[i] = fsq_pkg::OP_W'({a[i], 1'b0});
      re[i] = fsq_pkg::OP_W'({a[i], 4'b0}) + fsq_pkg::OP_W'({a[i], 1'b0}) + ae[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // column 0
      x[0]  <= ae[0]; y[0]  <= ae[0];
      x[1]  <= de[1]; y[1]  <= re[4];
      x[2]  <= de[2]; y[2]  <= re[3];
      // column 1
      x[3]  <= de[0]; y[3]  <= ae[1];
      x[4]  <= re[3]; y[4]  <= ae[3];
      x[5]  <= de[2]; y[5]  <= re[4];
      // column 2
      x[6]  <= de[0]; y[6]  <= ae[2];
      x[7]  <= ae[1]; y[7]  <= ae[1];
      x[8]  <= de[3]; y[8]  <= re[4];
      // column 3
      x[9]  <= de[0]; y[9]  <= ae[3];
      x[10] <= de[1]; y[10] <= ae[2];
      x[11] <= re[4]; y[11] <= ae[4];
      // column 4
      x[12] <= de[0]; y[12] <= ae[4];
      x[13] <= de[1]; y[13] <= ae[3];
      x[14] <= ae[2]; y[14] <= ae[2];
    end
  end

endmodule

[rtl/fsq_mul.sv]
// Two-stage 57x57 multiplier: four registered partial products, then their sum.
module fsq_mul (
  input  logic           clk,
  input  logic           en_pp,
  input  logic           en_prod,
  input  fsq_pkg::op_t   x,
  input  fsq_pkg::op_t   y,
  output fsq_pkg::prod_t prod
);

  logic [fsq_pkg::LO_W-1:0] xl, yl;
  logic [fsq_pkg::HI_W-1:0] xh, yh;

  logic [2*fsq_pkg::LO_W-1:0]            pp_ll;
  logic [fsq_pkg::LO_W+fsq_pkg::HI_W-1:0] pp_lh;
  logic [fsq_pkg::LO_W+fsq_pkg::HI_W-1:0] pp_hl;
  logic [2*fsq_pkg::HI_W-1:0]            pp_hh;

  assign xl = x[fsq_pkg::LO_W-1:0];
  assign xh = x[fsq_pkg::OP_W-1:fsq_pkg::LO_W];
  assign yl = y[fsq_pkg::LO_W-1:0];
  assign yh = y[fsq_pkg::OP_W-1:fsq_pkg::LO_W];

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_ll <= (2*fsq_pkg::LO_W)'(xl) * (2*fsq_pkg::LO_W)'(yl);
      pp_lh <= (fsq_pkg::LO_W+fsq_pkg::HI_W)'(xl) * (fsq_pkg::LO_W+fsq_pkg::HI_W)'(yh);
      pp_hl <= (fsq_pkg::LO_W+fsq_pkg::HI_W)'(xh) * (fsq_pkg::LO_W+fsq_pkg::HI_W)'(yl);
      pp_hh <= (2*fsq_pkg::HI_W)'(xh) * (2*fsq_pkg::HI_W)'(yh);
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod <= fsq_pkg::PROD_W'(pp_ll)
            + (fsq_pkg::PROD_W'(pp_lh) << fsq_pkg::LO_W)
            + (fsq_pkg::PROD_W'(pp_hl) << fsq_pkg::LO_W)
            + (fsq_pkg::PROD_W'(pp_hh) << (2*fsq_pkg::LO_W));
    end
  end

endmodule

[rtl/fsq_col.sv]
// Column stage: three products summed into each of five 112-bit columns.
module fsq_col (
  input  logic           clk,
  input  logic           en,
  input  fsq_pkg::prod_t prod [fsq_pkg::N_PROD],
  output fsq_pkg::col_t  col  [fsq_pkg::N_COL]
);

  // Column sums stay below 2^111, so the upper product bits are zero.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < fsq_pkg::N_COL; c++) begin
        col[c] <= fsq_pkg::COL_W'(prod[fsq_pkg::TERMS*c])
                + fsq_pkg::COL_W'(prod[fsq_pkg::TERMS*c+1])
                + fsq_pkg::COL_W'(prod[fsq_pkg::TERMS*c+2]);
      end
    end
  end

endmodule

[rtl/fsq_carry.sv]
// Carry chain: one column carry per stage, top carry folded by 19, output register.
module fsq_carry (
  input  logic                              clk,
  input  logic [fsq_pkg::CARRY_STAGES-1:0]  en,
  input  fsq_pkg::col_t                     col [fsq_pkg::N_COL],
  output fsq_pkg::limb_t                    limb0,
  output fsq_pkg::in_limb_t                 limb1,
  output fsq_pkg::limb_t                    limb2,
  output fsq_pkg::limb_t                    limb3,
  output fsq_pkg::limb_t                    limb4
);

  localparam int LW = fsq_pkg::LIMB_W;
  localparam int CW = fsq_pkg::COL_W;

  fsq_pkg::limb_t l0_a, l0_b, l0_c, l0_d;
  fsq_pkg::limb_t l1_b, l1_c, l1_d, l1_e;
  fsq_pkg::limb_t l2_c, l2_d, l2_e;
  fsq_pkg::limb_t l3_d, l3_e;
  fsq_pkg::limb_t l4_e;
  fsq_pkg::col_t  s1_a, c2_a, c3_a, c4_a;
  fsq_pkg::col_t  s2_b, c3_b, c4_b;
  fsq_pkg::col_t  s3_c, c4_c;
  fsq_pkg::col_t  s4_d;
  logic [fsq_pkg::FOLD_W-1:0] t_e;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l0_a <= col[0][LW-1:0];
      s1_a <= col[1] + CW'(col[0][CW-1:LW]);
      c2_a <= col[2];
      c3_a <= col[3];
      c4_a <= col[4];
    end
    if (en[1]) begin
      l0_b <= l0_a;
      l1_b <= s1_a[LW-1:0];
      s2_b <= c2_a + CW'(s1_a[CW-1:LW]);
      c3_b <= c3_a;
      c4_b <= c4_a;
    end
    if (en[2]) begin
      l0_c <= l0_b;
      l1_c <= l1_b;
      l2_c <= s2_b[LW-1:0];
      s3_c <= c3_b + CW'(s2_b[CW-1:LW]);
      c4_c <= c4_b;
    end
    if (en[3]) begin
      l0_d <= l0_c;
      l1_d <= l1_c;
      l2_d <= l2_c;
      l3_d <= s3_c[LW-1:0];
      s4_d <= c4_c + CW'(s3_c[CW-1:LW]);
    end
    // top carry stays below 2^56, so the fold fits 62 bits
    if (en[4]) begin
      l1_e <= l1_d;
      l2_e <= l2_d;
      l3_e <= l3_d;
      l4_e <= s4_d[LW-1:0];
      t_e  <= fsq_pkg::FOLD_W'(l0_d)
            + fsq_pkg::FOLD_W'(s4_d[CW-1:LW]) * fsq_pkg::FOLD_W'(fsq_pkg::FOLD);
    end
    if (en[5]) begin
      limb0 <= t_e[LW-1:0];
      limb1 <= fsq_pkg::IN_W'(l1_e) + fsq_pkg::IN_W'(t_e[fsq_pkg::FOLD_W-1:LW]);
      limb2 <= l2_e;
      limb3 <= l3_e;
      limb4 <= l4_e;
    end
  end

endmodule

[rtl/field_square_mod_p25519_top.sv]
// Top level: ten-stage pipelined square modulo 2^255-19 in radix 2^51.
//
// Usage:
//   operand (sink): five 52-bit limbs, transfer when valid and ready are high.
//   square (source): five limbs (limb 1 may carry a small excess above 51 bits),
//   congruent to the square of the operand but not fully reduced.
// An operand passes the prep, partial-product, product, column and carry
//   stages in that order; square.valid rises when it reaches the last stage.
// Throughput: one operand per cycle while square is not stalled; fifteen
//   57x57 products are each split at bit 29 into four partial products;
//   the carry chain takes a stage per column carry, a fold and an output stage.
// Every stage holds a valid bit; a stage loads when it is empty or when the
//   stage after it moves, so bubbles close up and a stalled receiver fills
//   the pipeline before operand.ready drops. Nothing is lost or repeated.
// Reset (rst, synchronous): clears all valid bits; the data registers
//   are not reset.
`include "field_square_mod_p25519_top_macros.svh"

module field_square_mod_p25519_top (
  input logic       clk,
  input logic       rst,
  fsq_in_if.sink    operand,
  fsq_out_if.source square
);

  localparam int NS = fsq_pkg::N_STAGES;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic          acc_in, acc_out;

  fsq_pkg::in_limb_t a    [fsq_pkg::N_LIMB];
  fsq_pkg::op_t      x    [fsq_pkg::N_PROD];
  fsq_pkg::op_t      y    [fsq_pkg::N_PROD];
  fsq_pkg::prod_t    prod [fsq_pkg::N_PROD];
  fsq_pkg::col_t     col  [fsq_pkg::N_COL];

  always_comb begin
    en[NS-1] = !v[NS-1] || square.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= operand.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign operand.ready = en[0];
  assign square.valid  = v[NS-1];
  assign acc_in        = operand.valid && operand.ready;
  assign acc_out       = square.valid && square.ready;

  assign a[0] = operand.limb0_in;
  assign a[1] = operand.limb1_in;
  assign a[2] = operand.limb2_in;
  assign a[3] = operand.limb3_in;
  assign a[4] = operand.limb4_in;

  fsq_prep u_prep (
    .clk (clk),
    .en  (en[fsq_pkg::ST_PREP]),
    .a   (a),
    .x   (x),
    .y   (y)
  );

  for (genvar p = 0; p < fsq_pkg::N_PROD; p++) begin : g_mul
    fsq_mul u_mul (
      .clk     (clk),
      .en_pp   (en[fsq_pkg::ST_PP]),
      .en_prod (en[fsq_pkg::ST_PROD]),
      .x       (x[p]),
      .y       (y[p]),
      .prod    (prod[p])
    );
  end

  fsq_col u_col (
    .clk  (clk),
    .en   (en[fsq_pkg::ST_COL]),
    .prod (prod),
    .col  (col)
  );

  fsq_carry u_carry (
    .clk   (clk),
    .en    (en[NS-1:fsq_pkg::ST_CARRY]),
    .col   (col),
    .limb0 (square.limb0_out),
    .limb1 (square.limb1_out),
    .limb2 (square.limb2_out),
    .limb3 (square.limb3_out),
    .limb4 (square.limb4_out)
  );

  `FSQ_ASSERT_IMP(a_stall_full, !operand.ready, (&v) && !square.ready,
                  "operand refused while the pipeline has room")
  `FSQ_ASSERT_IMP(a_occupancy, !$past(rst),
                  $countones(v) == $past($countones(v)) + $past(acc_in) - $past(acc_out),
                  "pipeline occupancy does not match transfers")
  `FSQ_ASSERT_IMP(a_limb1_excess, square.valid && square.limb1_out[fsq_pkg::IN_W-1],
                  square.limb1_out[fsq_pkg::LIMB_W-1:11] == '0,
                  "limb 1 excess above 51 bits too large")

endmodule
